>>> src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define EG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define EG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/eg_pkg.sv
// ----------------------------------------------------------------------------
// eg_pkg
// Shared constants and types of the Elias gamma encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package eg_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  // coded bits of the value port (the port is 32 bits wide)
  localparam int unsigned CODE_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int unsigned CNT_W  = $clog2(CODE_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ZEROS,
    S_BITS,
    S_ERR,
    S_FLUSH
  } eg_state_e;

  typedef enum logic [1:0] {
    TOK_BIT,
    TOK_ERR,
    TOK_FLUSH
  } eg_tok_kind_e;

  // one token from the serializer to the packer
  typedef struct packed {
    logic         valid;
    eg_tok_kind_e kind;
    logic         data;
    logic         item_end;
  } eg_tok_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       zero_error;
    logic       stream_done;
  } eg_res_t;

endpackage

`default_nettype wire

>>> src/eg_serializer.sv
// ----------------------------------------------------------------------------
// eg_serializer
// Bit-serial gamma coder: finds the leading one by shifting, then sends the
// zero prefix and value bits MSB first, one token per cycle when not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module eg_serializer
  import eg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CODE_W-1:0] value_i,
  input  wire logic              end_of_stream_i,
  output eg_tok_t                tok_o,
  input  wire logic              tok_ready_i
);

  eg_state_e         state_q, state_d;
  logic [CODE_W-1:0] sh_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  top_q;
  logic              eos_q;

  logic msb;
  assign msb = sh_q[CODE_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = (value_i == '0) ? S_ERR : S_SCAN;
      end
      S_SCAN: begin
        if (msb) state_d = (cnt_q == '0) ? S_BITS : S_ZEROS;
      end
      S_ZEROS: begin
        if (tok_ready_i && cnt_q == CNT_W'(1)) state_d = S_BITS;
      end
      S_BITS: begin
        if (tok_ready_i && cnt_q == '0) state_d = eos_q ? S_FLUSH : S_IDLE;
      end
      S_ERR: begin
        if (tok_ready_i) state_d = eos_q ? S_FLUSH : S_IDLE;
      end
      S_FLUSH: begin
        if (tok_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    tok_o.valid    = 1'b0;
    tok_o.kind     = TOK_BIT;
    tok_o.data     = 1'b0;
    tok_o.item_end = 1'b0;
    unique case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_SCAN:  ;
      S_ZEROS: tok_o.valid = 1'b1;
      S_BITS: begin
        tok_o.valid    = 1'b1;
        tok_o.data     = msb;
        tok_o.item_end = (cnt_q == '0) && !eos_q;
      end
      S_ERR: begin
        tok_o.valid    = 1'b1;
        tok_o.kind     = TOK_ERR;
        tok_o.item_end = !eos_q;
      end
      S_FLUSH: begin
        tok_o.valid    = 1'b1;
        tok_o.kind     = TOK_FLUSH;
        tok_o.item_end = 1'b1;
      end
      default: ;
    endcase
  end

  // datapath: cnt counts down the scan position, then zeros, then value bits
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sh_q  <= value_i;
          eos_q <= end_of_stream_i;
          cnt_q <= CNT_W'(CODE_W - 1);
        end
      end
      S_SCAN: begin
        if (msb) begin
          top_q <= cnt_q;
        end else begin
          sh_q  <= {sh_q[CODE_W-2:0], 1'b0};
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
      S_ZEROS: begin
        if (tok_ready_i) begin
          cnt_q <= (cnt_q == CNT_W'(1)) ? top_q : cnt_q - CNT_W'(1);
        end
      end
      S_BITS: begin
        if (tok_ready_i) begin
          sh_q  <= {sh_q[CODE_W-2:0], 1'b0};
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/eg_packer.sv
// ----------------------------------------------------------------------------
// eg_packer
// Packs code bits MSB first into bytes. A finished byte waits in a hold
// register until the next byte or the item's end shows if it is the last.
// ----------------------------------------------------------------------------
`default_nettype none

module eg_packer
  import eg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire eg_tok_t    tok_i,
  output logic            tok_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            zero_error_o,
  output logic            stream_done_o
);

  logic [7:0] pb_q;
  logic [2:0] fill_q;
  logic       hold_valid_q, hold_closed_q;
  eg_res_t    hold_q;
  logic       out_valid_q;
  eg_res_t    out_q;

  logic       produce;
  logic [7:0] res_byte;
  logic       res_err;
  logic       out_free, hold_blocked, move_closed, need_out, consume;
  logic       is_flush;

  always_comb begin
    produce  = 1'b0;
    res_byte = 8'd0;
    res_err  = 1'b0;
    unique case (tok_i.kind)
      TOK_BIT: begin
        produce  = (fill_q == 3'd7);
        res_byte = {pb_q[6:0], tok_i.data};
      end
      TOK_ERR: begin
        produce = 1'b1;
        res_err = 1'b1;
      end
      TOK_FLUSH: begin
        produce  = (fill_q != 3'd0);
        res_byte = pb_q << (4'd8 - {1'b0, fill_q});
      end
      default: ;
    endcase
  end

  assign is_flush     = (tok_i.kind == TOK_FLUSH);
  assign out_free     = !out_valid_q || out_ready_i;
  assign hold_blocked = hold_valid_q && hold_closed_q;
  assign move_closed  = hold_blocked && out_free;
  assign need_out     = produce && hold_valid_q;
  assign tok_ready_o  = !hold_blocked && (!need_out || out_free);
  assign consume      = tok_i.valid && tok_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_q          <= 8'd0;
      fill_q        <= 3'd0;
      hold_valid_q  <= 1'b0;
      hold_closed_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (move_closed) begin
        out_valid_q  <= 1'b1;
        hold_valid_q <= 1'b0;
      end else if (consume && need_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (consume) begin
        if (produce) begin
          hold_valid_q  <= 1'b1;
          hold_closed_q <= tok_i.item_end;
        end else if (tok_i.item_end) begin
          hold_closed_q <= 1'b1;
        end
        unique case (tok_i.kind)
          TOK_BIT: begin
            pb_q   <= (fill_q == 3'd7) ? 8'd0 : {pb_q[6:0], tok_i.data};
            fill_q <= fill_q + 3'd1;
          end
          TOK_ERR: ;
          TOK_FLUSH: begin
            pb_q   <= 8'd0;
            fill_q <= 3'd0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // an open hold never carries run_last or stream_done
    if (move_closed || (consume && need_out)) begin
      out_q <= hold_q;
    end
    if (consume) begin
      if (produce) begin
        hold_q.out_byte    <= res_byte;
        hold_q.zero_error  <= res_err;
        hold_q.run_last    <= tok_i.item_end;
        hold_q.stream_done <= is_flush;
      end else if (tok_i.item_end) begin
        hold_q.run_last    <= 1'b1;
        hold_q.stream_done <= is_flush;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_q.out_byte;
  assign run_last_o    = out_q.run_last;
  assign zero_error_o  = out_q.zero_error;
  assign stream_done_o = out_q.stream_done;

endmodule

`default_nettype wire

>>> src/elias_gamma_encoder.sv
// The encoder takes one value at a time: a bit-serial shift register scans
// for the leading one, then sends one code bit a cycle unless the packer
// stalls. Each byte waits in a hold register for the next byte or the
// item's end before it reaches the output.
// Reset (async, active low) empties the packer.
// ----------------------------------------------------------------------------
// elias_gamma_encoder
// Elias gamma encoder with MSB-first packed byte output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module elias_gamma_encoder
  import eg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] value_i,
  input  wire logic        end_of_stream_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             run_last_o,
  output logic             zero_error_o,
  output logic             stream_done_o
);

  eg_tok_t tok;
  logic    tok_ready;

  eg_serializer u_ser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .value_i         (value_i[CODE_W-1:0]),
    .end_of_stream_i (end_of_stream_i),
    .tok_o           (tok),
    .tok_ready_i     (tok_ready)
  );

  eg_packer u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tok_i         (tok),
    .tok_ready_o   (tok_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .zero_error_o  (zero_error_o),
    .stream_done_o (stream_done_o)
  );

  `EG_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "accepted while busy")
  `EG_ASSERT(a_done_is_last, (out_valid_o && stream_done_o) |-> run_last_o, "stream_done without run_last")
  `EG_ASSERT(a_no_tok_when_idle, in_ready_o |-> !tok.valid, "token while serializer idle")
  `EG_ASSERT_ALWAYS(a_err_byte_zero, (out_valid_o && zero_error_o) |-> (out_byte_o == 8'd0), "error byte not zero")

endmodule

`default_nettype wire
